### rtl/core/abs_pkg.sv
`timescale 1ns / 1ps
package abs_pkg;

  // fixed field widths
  localparam int VTX_W        = 8;
  localparam int CHUNK_IDX_W  = 6;
  localparam int CHUNK_BITS_W = 16;
  localparam int CMD_W        = 2;

  // storage word geometry
  localparam int WORD_BITS = 32;
  localparam int LOG_WB    = $clog2(WORD_BITS);

  // parameter defaults
  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_CHUNK_SIZE   = 4;

  // depth of the job queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef logic [CMD_W-1:0] cmd_t;

  // command codes
  localparam cmd_t CMD_ADD   = 2'd0;
  localparam cmd_t CMD_QUERY = 2'd1;
  localparam cmd_t CMD_CHUNK = 2'd2;
  localparam cmd_t CMD_NONE  = 2'd3;

  // classified job; for a chunk read, u carries the block base vertex
  typedef struct packed {
    cmd_t             op;
    logic             in_range;
    logic [VTX_W-1:0] u;
    logic [VTX_W-1:0] v;
  } job_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### rtl/core/adjacency_bitmap_store_top.sv
`timescale 1ns / 1ps
// Bit-packed adjacency matrix store. Commands are taken when start is high
// and busy is low: add an undirected edge, query one edge, or read a
// CHUNK_SIZE by CHUNK_SIZE diagonal block. Query and chunk reads return one
// result, marked by out_valid for exactly one cycle; the receiver cannot
// stall, so it must take every result when it appears. Adds and the unused
// command give no result. All work goes through one single-port word memory,
// one access per cycle: an add does two read-modify-writes, a query at most
// one read, and a chunk read two reads per block row. A two-entry job queue
// sits between the command front and the memory sequencer, so commands are
// taken while the sequencer works. After reset the store is zeroed word by
// word over MAX_VERTICES * ceil(MAX_VERTICES/32) words (2048 by default),
// during which busy stays high.
module adjacency_bitmap_store_top import abs_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int CHUNK_SIZE   = DEF_CHUNK_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [CMD_W-1:0]        in_cmd,
  input  logic [VTX_W-1:0]        in_vertex_u,
  input  logic [VTX_W-1:0]        in_vertex_v,
  input  logic [CHUNK_IDX_W-1:0]  in_chunk_index,
  output logic                    out_valid,
  output logic                    out_edge_present,
  output logic [CHUNK_BITS_W-1:0] out_chunk_bits
);

  logic    push;
  job_t    push_job;
  logic    pop;
  job_t    head;
  q_stat_t q_stat;
  logic    clearing;

  // command front
  abs_front #(
    .MAX_VERTICES (MAX_VERTICES),
    .CHUNK_SIZE   (CHUNK_SIZE)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_vertex_u    (in_vertex_u),
    .in_vertex_v    (in_vertex_v),
    .in_chunk_index (in_chunk_index),
    .q_stat         (q_stat),
    .clearing       (clearing),
    .push           (push),
    .push_job       (push_job)
  );

  // job queue
  abs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // memory sequencer
  abs_back #(
    .MAX_VERTICES (MAX_VERTICES),
    .CHUNK_SIZE   (CHUNK_SIZE)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (head),
    .q_stat           (q_stat),
    .pop              (pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_edge_present (out_edge_present),
    .out_chunk_bits   (out_chunk_bits)
  );

  // no two result strobes come back to back
  a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result strobes");

  // a result is either a query or a chunk read, never both
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_chunk_bits != '0) |-> !out_edge_present)
    else $error("query and chunk result mixed");

  // no transaction is taken during the clearing pass
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> busy)
    else $error("command accepted while clearing");

  // no push into a full queue, no pop from an empty one
  a_queue_flow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_stat.full) && !(pop && q_stat.empty))
    else $error("queue overflow or underflow");

endmodule

### rtl/core/abs_front.sv
`timescale 1ns / 1ps
module abs_front import abs_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int CHUNK_SIZE   = DEF_CHUNK_SIZE
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  cmd_t                   in_cmd,
  input  logic [VTX_W-1:0]       in_vertex_u,
  input  logic [VTX_W-1:0]       in_vertex_v,
  input  logic [CHUNK_IDX_W-1:0] in_chunk_index,
  input  q_stat_t                q_stat,
  input  logic                   clearing,
  output logic                   push,
  output job_t                   push_job
);

  logic             accept;
  logic             in_range;
  logic [VTX_W-1:0] chunk_base;
  logic             keep;
  logic             clearing_r;

  // registered copy of the clear status, kept for a clean busy path
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
    end else begin
      clearing_r <= clearing;
    end
  end

  // hold off while the store is being cleared or the queue is full
  assign busy   = q_stat.full || clearing || clearing_r;
  assign accept = start && !busy;

  // classify the transaction
  assign in_range   = (32'(in_vertex_u) < 32'(MAX_VERTICES)) &&
                      (32'(in_vertex_v) < 32'(MAX_VERTICES));
  assign chunk_base = VTX_W'(32'(in_chunk_index) * 32'(CHUNK_SIZE));

  always_comb begin
    case (in_cmd)
      CMD_ADD:   keep = in_range;
      CMD_QUERY: keep = 1'b1;
      CMD_CHUNK: keep = 1'b1;
      default:   keep = 1'b0;
    endcase
  end

  // out-of-range adds and unused commands are dropped here
  assign push              = accept && keep;
  assign push_job.op       = in_cmd;
  assign push_job.in_range = in_range;
  assign push_job.u        = (in_cmd == CMD_CHUNK) ? chunk_base : in_vertex_u;
  assign push_job.v        = in_vertex_v;

endmodule

### rtl/core/abs_queue.sv
`timescale 1ns / 1ps
module abs_queue import abs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t q_stat
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r;
  logic [PW-1:0] rd_ptr_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] cnt_nxt;

  // pointer wrap
  assign wr_ptr_nxt = (wr_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
  assign rd_ptr_nxt = (rd_ptr_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

  // job slots
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  assign head         = slot_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == CW'(QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

endmodule

### rtl/core/abs_back.sv
`timescale 1ns / 1ps
module abs_back import abs_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int CHUNK_SIZE   = DEF_CHUNK_SIZE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  job_t                    head,
  input  q_stat_t                 q_stat,
  output logic                    pop,
  output logic                    clearing,
  output logic                    out_valid,
  output logic                    out_edge_present,
  output logic [CHUNK_BITS_W-1:0] out_chunk_bits
);

  localparam int ROW_WORDS = (MAX_VERTICES + WORD_BITS - 1) / WORD_BITS;
  localparam int DEPTH     = MAX_VERTICES * ROW_WORDS;
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RCW       = (CHUNK_SIZE > 1) ? $clog2(CHUNK_SIZE) : 1;
  localparam int CWW       = VTX_W - LOG_WB;

  localparam logic [3:0] S_CLEAR   = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_ADD_RD1 = 4'd2;
  localparam logic [3:0] S_ADD_WR1 = 4'd3;
  localparam logic [3:0] S_ADD_RD2 = 4'd4;
  localparam logic [3:0] S_ADD_WR2 = 4'd5;
  localparam logic [3:0] S_Q_RD    = 4'd6;
  localparam logic [3:0] S_Q_WAIT  = 4'd7;
  localparam logic [3:0] S_C_RD0   = 4'd8;
  localparam logic [3:0] S_C_RD1   = 4'd9;
  localparam logic [3:0] S_C_EXT   = 4'd10;

  // word address of bit (r, c)
  function automatic logic [AW-1:0] word_addr(input logic [VTX_W-1:0] r,
                                              input logic [VTX_W-1:0] c);
    logic [31:0] a;
    a = 32'(r) * 32'(ROW_WORDS) + 32'(c[VTX_W-1:LOG_WB]);
    return a[AW-1:0];
  endfunction

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] mem_rdata_r;
  logic                 mem_we;
  logic                 mem_re;
  logic [AW-1:0]        mem_addr;
  logic [WORD_BITS-1:0] mem_wdata;

  logic [3:0]              state_r, state_nxt;
  job_t                    job_r, job_nxt;
  logic [AW-1:0]           clr_cnt_r, clr_cnt_nxt;
  logic [RCW-1:0]          row_r, row_nxt;
  logic [CHUNK_BITS_W-1:0] acc_r, acc_nxt;
  logic [WORD_BITS-1:0]    w0_r, w0_nxt;
  logic                    rd0_ok_r, rd0_ok_nxt;
  logic                    rd1_ok_r, rd1_ok_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_edge_r, out_edge_nxt;
  logic [CHUNK_BITS_W-1:0] out_chunk_r, out_chunk_nxt;

  // chunk row geometry
  logic [VTX_W-1:0]       row_addr;
  logic                   row_ok;
  logic [CWW-1:0]         col_word;
  logic [LOG_WB-1:0]      col_off;
  logic [AW-1:0]          addr0;
  logic                   rd0;
  logic                   rd1;
  logic                   row_spans;
  logic [CHUNK_SIZE-1:0]  col_ok;
  logic [2*WORD_BITS-1:0] win;
  logic [WORD_BITS-1:0]   w1_eff;
  logic [WORD_BITS-1:0]   w0_eff;
  logic [CHUNK_SIZE-1:0]  row_bits;
  logic                   last_row;

  assign row_addr  = job_r.u + VTX_W'(row_r);
  assign row_ok    = 32'(row_addr) < 32'(MAX_VERTICES);
  assign col_word  = job_r.u[VTX_W-1:LOG_WB];
  assign col_off   = job_r.u[LOG_WB-1:0];
  assign addr0     = word_addr(row_addr, job_r.u);
  assign row_spans = (32'(col_off) + 32'(CHUNK_SIZE)) > 32'(WORD_BITS);
  assign rd0       = row_ok && (32'(col_word) < 32'(ROW_WORDS));
  assign rd1       = row_ok && row_spans && ((32'(col_word) + 32'd1) < 32'(ROW_WORDS));
  assign last_row  = (row_r == RCW'(CHUNK_SIZE - 1));

  always_comb begin
    for (int j = 0; j < CHUNK_SIZE; j++) begin
      col_ok[j] = (32'(job_r.u) + 32'(j)) < 32'(MAX_VERTICES);
    end
  end

  // gather one block row out of one or two words
  assign w0_eff   = rd0_ok_r ? w0_r : '0;
  assign w1_eff   = rd1_ok_r ? mem_rdata_r : '0;
  assign win      = {w1_eff, w0_eff} >> col_off;
  assign row_bits = win[CHUNK_SIZE-1:0] & col_ok & {CHUNK_SIZE{row_ok}};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    clr_cnt_nxt   = clr_cnt_r;
    row_nxt       = row_r;
    acc_nxt       = acc_r;
    w0_nxt        = w0_r;
    rd0_ok_nxt    = rd0_ok_r;
    rd1_ok_nxt    = rd1_ok_r;
    out_valid_nxt = 1'b0;
    out_edge_nxt  = out_edge_r;
    out_chunk_nxt = out_chunk_r;
    pop           = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_addr      = '0;
    mem_wdata     = '0;
    case (state_r)
      S_CLEAR: begin
        mem_we   = 1'b1;
        mem_addr = clr_cnt_r;
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop     = 1'b1;
          job_nxt = head;
          row_nxt = '0;
          acc_nxt = '0;
          case (head.op)
            CMD_ADD:   state_nxt = S_ADD_RD1;
            CMD_QUERY: state_nxt = S_Q_RD;
            CMD_CHUNK: state_nxt = S_C_RD0;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_RD1: begin
        mem_re    = 1'b1;
        mem_addr  = word_addr(job_r.u, job_r.v);
        state_nxt = S_ADD_WR1;
      end
      S_ADD_WR1: begin
        mem_we    = 1'b1;
        mem_addr  = word_addr(job_r.u, job_r.v);
        mem_wdata = mem_rdata_r | (WORD_BITS'(1) << job_r.v[LOG_WB-1:0]);
        state_nxt = S_ADD_RD2;
      end
      S_ADD_RD2: begin
        mem_re    = 1'b1;
        mem_addr  = word_addr(job_r.v, job_r.u);
        state_nxt = S_ADD_WR2;
      end
      S_ADD_WR2: begin
        mem_we    = 1'b1;
        mem_addr  = word_addr(job_r.v, job_r.u);
        mem_wdata = mem_rdata_r | (WORD_BITS'(1) << job_r.u[LOG_WB-1:0]);
        state_nxt = S_IDLE;
      end
      S_Q_RD: begin
        mem_re    = job_r.in_range;
        mem_addr  = word_addr(job_r.u, job_r.v);
        state_nxt = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        out_valid_nxt = 1'b1;
        out_edge_nxt  = job_r.in_range & mem_rdata_r[job_r.v[LOG_WB-1:0]];
        out_chunk_nxt = '0;
        state_nxt     = S_IDLE;
      end
      S_C_RD0: begin
        mem_re     = rd0;
        mem_addr   = addr0;
        rd0_ok_nxt = rd0;
        state_nxt  = S_C_RD1;
      end
      S_C_RD1: begin
        w0_nxt     = mem_rdata_r;
        mem_re     = rd1;
        mem_addr   = addr0 + AW'(1);
        rd1_ok_nxt = rd1;
        state_nxt  = S_C_EXT;
      end
      S_C_EXT: begin
        acc_nxt = acc_r | (CHUNK_BITS_W'(row_bits) << (row_r * CHUNK_SIZE));
        if (last_row) begin
          out_valid_nxt = 1'b1;
          out_edge_nxt  = 1'b0;
          out_chunk_nxt = acc_nxt;
          state_nxt     = S_IDLE;
        end else begin
          row_nxt   = row_r + RCW'(1);
          state_nxt = S_C_RD0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    row_r       <= row_nxt;
    acc_r       <= acc_nxt;
    w0_r        <= w0_nxt;
    rd0_ok_r    <= rd0_ok_nxt;
    rd1_ok_r    <= rd1_ok_nxt;
    out_edge_r  <= out_edge_nxt;
    out_chunk_r <= out_chunk_nxt;
  end

  // adjacency word store, one access per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= mem[mem_addr];
    end
  end

  assign clearing         = (state_r == S_CLEAR);
  assign out_valid        = out_valid_r;
  assign out_edge_present = out_edge_r;
  assign out_chunk_bits   = out_chunk_r;

endmodule

### verif/tb_adjacency_bitmap_store_top.sv
`timescale 1ns / 1ps
module tb_adjacency_bitmap_store_top;
  import abs_pkg::*;

  localparam int NUM_VTX      = DEF_MAX_VERTICES;
  localparam int BLK          = DEF_CHUNK_SIZE;
  localparam int RANDOM_CMDS  = 1800;
  localparam int DRAIN_CYCLES = 64;
  localparam int NUM_HOT      = 8;

  typedef struct {
    cmd_t                   op;
    logic [VTX_W-1:0]       u;
    logic [VTX_W-1:0]       v;
    logic [CHUNK_IDX_W-1:0] chunk;
  } graph_cmd_t;

  typedef struct {
    cmd_t                    op;
    logic                    edge_present;
    logic [CHUNK_BITS_W-1:0] chunk_bits;
  } graph_result_t;

  logic                    clk   = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    start = 1'b0;
  logic                    busy;
  logic [CMD_W-1:0]        in_cmd         = '0;
  logic [VTX_W-1:0]        in_vertex_u    = '0;
  logic [VTX_W-1:0]        in_vertex_v    = '0;
  logic [CHUNK_IDX_W-1:0]  in_chunk_index = '0;
  logic                    out_valid;
  logic                    out_edge_present;
  logic [CHUNK_BITS_W-1:0] out_chunk_bits;

  // clock
  always #1 clk = ~clk;

  adjacency_bitmap_store_top u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_vertex_u      (in_vertex_u),
    .in_vertex_v      (in_vertex_v),
    .in_chunk_index   (in_chunk_index),
    .out_valid        (out_valid),
    .out_edge_present (out_edge_present),
    .out_chunk_bits   (out_chunk_bits)
  );

  // shadow copy of the adjacency matrix, one row per vertex
  bit [NUM_VTX-1:0] adj_matrix [NUM_VTX];

  graph_cmd_t    pending_cmds[$];
  graph_result_t expected_results[$];
  graph_cmd_t    known_adds[$];
  graph_result_t oldest_result;
  int            hot_chunk [NUM_HOT];

  int burst_left      = 1;
  int gap_left        = 0;
  int fail_count      = 0;
  int adds_done       = 0;
  int ignored_cmds    = 0;
  int queries_checked = 0;
  int chunks_checked  = 0;

  // update the shadow matrix and queue the result a transaction should produce
  function automatic void apply_graph_cmd(input graph_cmd_t c);
    graph_result_t res;
    int            base;
    res.op           = c.op;
    res.edge_present = 1'b0;
    res.chunk_bits   = '0;
    case (c.op)
      CMD_ADD: begin
        if (c.u < NUM_VTX && c.v < NUM_VTX) begin
          adj_matrix[c.u][c.v] = 1'b1;
          adj_matrix[c.v][c.u] = 1'b1;
        end
        adds_done++;
      end
      CMD_QUERY: begin
        if (c.u < NUM_VTX && c.v < NUM_VTX)
          res.edge_present = adj_matrix[c.u][c.v];
        expected_results.push_back(res);
      end
      CMD_CHUNK: begin
        base = int'(c.chunk) * BLK;
        for (int i = 0; i < BLK; i++) begin
          for (int j = 0; j < BLK; j++) begin
            if (base + i < NUM_VTX && base + j < NUM_VTX)
              res.chunk_bits[i*BLK+j] = adj_matrix[base+i][base+j];
          end
        end
        expected_results.push_back(res);
      end
      default: begin
        ignored_cmds++;
      end
    endcase
  endfunction

  function automatic void queue_cmd(input cmd_t op, input int u, input int v, input int chunk);
    graph_cmd_t c;
    c.op    = op;
    c.u     = u[VTX_W-1:0];
    c.v     = v[VTX_W-1:0];
    c.chunk = chunk[CHUNK_IDX_W-1:0];
    pending_cmds.push_back(c);
  endfunction

  // mostly vertices inside a few busy chunks so blocks and queries see set bits
  function automatic int pick_vertex();
    if ($urandom_range(0, 9) < 6)
      return hot_chunk[$urandom_range(0, NUM_HOT-1)] * BLK + $urandom_range(0, BLK-1);
    return $urandom_range(0, NUM_VTX-1);
  endfunction

  // driver: bursts of transactions with random gaps, noise on the fields while idle
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_graph_cmd(pending_cmds.pop_front());
      end
      if (start && busy) begin
        // hold the current transaction until it is taken
      end else if (gap_left > 0) begin
        gap_left--;
        start          <= 1'b0;
        in_cmd         <= cmd_t'($urandom_range(0, 3));
        in_vertex_u    <= VTX_W'($urandom_range(0, NUM_VTX-1));
        in_vertex_v    <= VTX_W'($urandom_range(0, NUM_VTX-1));
        in_chunk_index <= CHUNK_IDX_W'($urandom_range(0, 63));
      end else if (pending_cmds.size() != 0) begin
        start          <= 1'b1;
        in_cmd         <= pending_cmds[0].op;
        in_vertex_u    <= pending_cmds[0].u;
        in_vertex_v    <= pending_cmds[0].v;
        in_chunk_index <= pending_cmds[0].chunk;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 12);
          gap_left   = $urandom_range(1, 20);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: every strobed result is checked against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: edge_present %0d chunk_bits 0x%04h",
               out_edge_present, out_chunk_bits);
        fail_count++;
      end else begin
        oldest_result = expected_results.pop_front();
        if (out_edge_present !== oldest_result.edge_present) begin
          $error("edge_present mismatch: expected %0d, actual %0d",
                 oldest_result.edge_present, out_edge_present);
          fail_count++;
        end
        if (out_chunk_bits !== oldest_result.chunk_bits) begin
          $error("chunk_bits mismatch: expected 0x%04h, actual 0x%04h",
                 oldest_result.chunk_bits, out_chunk_bits);
          fail_count++;
        end
        if (oldest_result.op == CMD_QUERY)
          queries_checked++;
        else
          chunks_checked++;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    graph_cmd_t c;
    graph_cmd_t k;
    int         made;
    int         sel;

    // directed: empty store, extremes, self loops, ignored command, word boundary
    queue_cmd(CMD_QUERY, 0, 0, 0);
    queue_cmd(CMD_CHUNK, 255, 255, 0);
    queue_cmd(CMD_CHUNK, 0, 0, 63);
    queue_cmd(CMD_ADD, 0, 0, 63);
    queue_cmd(CMD_QUERY, 0, 0, 63);
    queue_cmd(CMD_ADD, 0, 255, 0);
    queue_cmd(CMD_QUERY, 255, 0, 0);
    queue_cmd(CMD_QUERY, 0, 255, 0);
    queue_cmd(CMD_ADD, 255, 255, 0);
    queue_cmd(CMD_CHUNK, 0, 0, 63);
    queue_cmd(CMD_CHUNK, 0, 0, 0);
    queue_cmd(CMD_NONE, 5, 6, 1);
    queue_cmd(CMD_QUERY, 5, 6, 0);
    queue_cmd(CMD_ADD, 29, 30, 0);
    queue_cmd(CMD_ADD, 28, 31, 0);
    queue_cmd(CMD_ADD, 30, 30, 0);
    queue_cmd(CMD_ADD, 31, 32, 0);
    queue_cmd(CMD_CHUNK, 0, 0, 7);
    queue_cmd(CMD_CHUNK, 0, 0, 8);
    queue_cmd(CMD_ADD, 170, 85, 0);
    queue_cmd(CMD_QUERY, 85, 170, 0);
    queue_cmd(CMD_ADD, 1, 2, 0);
    queue_cmd(CMD_CHUNK, 170, 85, 0);
    queue_cmd(CMD_CHUNK, 0, 0, 42);
    queue_cmd(CMD_CHUNK, 0, 0, 21);

    // random: adds, queries that often replay known edges, block reads, unused commands
    hot_chunk[0] = 0;
    hot_chunk[1] = 63;
    for (int h = 2; h < NUM_HOT; h++)
      hot_chunk[h] = $urandom_range(0, 63);
    made = 0;
    while (made < RANDOM_CMDS) begin
      sel     = $urandom_range(0, 99);
      c.u     = VTX_W'(pick_vertex());
      c.v     = VTX_W'(pick_vertex());
      c.chunk = CHUNK_IDX_W'($urandom_range(0, 63));
      if (sel < 35) begin
        c.op = CMD_ADD;
        known_adds.push_back(c);
        made++;
      end else if (sel < 65) begin
        c.op = CMD_QUERY;
        if (known_adds.size() != 0 && $urandom_range(0, 1) == 1) begin
          k = known_adds[$urandom_range(0, known_adds.size()-1)];
          if ($urandom_range(0, 1) == 1) begin
            c.u = k.v;
            c.v = k.u;
          end else begin
            c.u = k.u;
            c.v = k.v;
          end
        end
        made++;
      end else if (sel < 97) begin
        c.op = CMD_CHUNK;
        if ($urandom_range(0, 9) < 7)
          c.chunk = CHUNK_IDX_W'(hot_chunk[$urandom_range(0, NUM_HOT-1)]);
        made++;
      end else begin
        c.op = CMD_NONE;
      end
      pending_cmds.push_back(c);
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_cmds.size() != 0 || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      fail_count++;
    end

    $display("covered %0d edge adds, %0d edge queries, %0d block reads, %0d unused commands",
             adds_done, queries_checked, chunks_checked, ignored_cmds);
    $display("mismatches and stray results: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #1000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
